// File: sv/sea_pkg.sv
package sea_pkg;

   // operand and destination codes for the sequencer registers
   localparam logic [2:0] R_MA  = 3'd0;
   localparam logic [2:0] R_MS  = 3'd1;
   localparam logic [2:0] R_LA  = 3'd2;
   localparam logic [2:0] R_LS  = 3'd3;
   localparam logic [2:0] R_TMP = 3'd4;
   localparam logic [2:0] R_TS  = 3'd5;
   localparam logic [2:0] R_TAU = 3'd6;  // read only, as destination means no write

   // coefficient codes
   localparam logic [2:0] C_GEAR  = 3'd0;
   localparam logic [2:0] C_STIFF = 3'd1;
   localparam logic [2:0] C_MDAMP = 3'd2;
   localparam logic [2:0] C_LDAMP = 3'd3;
   localparam logic [2:0] C_INVJM = 3'd4;
   localparam logic [2:0] C_INVJL = 3'd5;
   localparam logic [2:0] C_DT    = 3'd6;

   // combine operations after the scaled product
   localparam logic [2:0] OP_TERM            = 3'd0;
   localparam logic [2:0] OP_TERM_MINUS_BASE = 3'd1;
   localparam logic [2:0] OP_BASE_MINUS_TERM = 3'd2;
   localparam logic [2:0] OP_BASE_PLUS_TERM  = 3'd3;
   localparam logic [2:0] OP_ACC_LOAD        = 3'd4;
   localparam logic [2:0] OP_ACC_MINUS       = 3'd5;

   // configuration register indexes
   localparam logic [2:0] CSR_INV_MOTOR_INERTIA = 3'd0;
   localparam logic [2:0] CSR_INV_LOAD_INERTIA  = 3'd1;
   localparam logic [2:0] CSR_MOTOR_DAMPING     = 3'd2;
   localparam logic [2:0] CSR_LOAD_DAMPING      = 3'd3;
   localparam logic [2:0] CSR_GEAR_RATIO        = 3'd4;
   localparam logic [2:0] CSR_SPRING_STIFFNESS  = 3'd5;
   localparam logic [2:0] CSR_TIME_STEP         = 3'd6;

   // configuration reset values
   localparam logic [30:0] RST_INV_MOTOR_INERTIA = 31'd6553600;
   localparam logic [30:0] RST_INV_LOAD_INERTIA  = 31'd1310720;
   localparam logic [30:0] RST_MOTOR_DAMPING     = 31'd1311;
   localparam logic [30:0] RST_LOAD_DAMPING      = 31'd3277;
   localparam logic [30:0] RST_GEAR_RATIO        = 31'd3276800;
   localparam logic [30:0] RST_SPRING_STIFFNESS  = 31'd13107200;
   localparam logic [31:0] RST_TIME_STEP         = 32'd4294967;

   localparam logic [3:0] STEP_LAST = 4'd12;

   typedef struct packed {
      logic [2:0] coef_sel;
      logic [2:0] val_sel;
      logic       shift32;
      logic [2:0] op;
      logic [2:0] base_sel;
      logic [2:0] dst_sel;
   } ctrl_type;

   // microcode: one multiply-and-combine per step
   function automatic ctrl_type step_ctrl(input logic [3:0] step);
      ctrl_type c;
      c = '{coef_sel: C_GEAR, val_sel: R_MA, shift32: 1'b0, op: OP_TERM,
            base_sel: R_TS, dst_sel: R_TAU};
      case (step)
         4'd0, 4'd11: begin
            c = '{C_GEAR, R_MA, 1'b0, OP_TERM_MINUS_BASE, R_LA, R_TMP};
         end
         4'd1, 4'd12: begin
            c = '{C_STIFF, R_TMP, 1'b0, OP_TERM, R_TS, R_TS};
         end
         4'd2: begin
            c = '{C_MDAMP, R_MS, 1'b0, OP_ACC_LOAD, R_TAU, R_TAU};
         end
         4'd3: begin
            c = '{C_GEAR, R_TS, 1'b0, OP_ACC_MINUS, R_TS, R_TMP};
         end
         4'd4: begin
            c = '{C_INVJM, R_TMP, 1'b0, OP_TERM, R_TS, R_TMP};
         end
         4'd5: begin
            c = '{C_DT, R_TMP, 1'b1, OP_BASE_PLUS_TERM, R_MS, R_MS};
         end
         4'd6: begin
            c = '{C_DT, R_MS, 1'b1, OP_BASE_PLUS_TERM, R_MA, R_MA};
         end
         4'd7: begin
            c = '{C_LDAMP, R_LS, 1'b0, OP_BASE_MINUS_TERM, R_TS, R_TMP};
         end
         4'd8: begin
            c = '{C_INVJL, R_TMP, 1'b0, OP_TERM, R_TS, R_TMP};
         end
         4'd9: begin
            c = '{C_DT, R_TMP, 1'b1, OP_BASE_PLUS_TERM, R_LS, R_LS};
         end
         4'd10: begin
            c = '{C_DT, R_LS, 1'b1, OP_BASE_PLUS_TERM, R_LA, R_LA};
         end
         default: begin
            c = '{C_GEAR, R_MA, 1'b0, OP_TERM, R_TS, R_TAU};
         end
      endcase
      return c;
   endfunction

endpackage

// File: sv/series_elastic_actuator_step_unit.sv
// a request runs 13 steps, a multiply state then a combine state each, then output load
// the next request is taken only once the last leaves output load; all products go through
//   the single shared 32x32 multiplier, one multiply then one combine per step
// reset (synchronous, active high): states cleared to zero, coefficients to defaults,
//   sequencer idle, no response pending
module series_elastic_actuator_step_unit (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_motor_torque,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_spring_torque,
   output logic signed [31:0] rsp_motor_angle,
   output logic signed [31:0] rsp_motor_speed,
   output logic signed [31:0] rsp_load_angle,
   output logic signed [31:0] rsp_load_speed,
   // configuration write port
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_COMB = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   localparam logic signed [33:0] SAT_MAX = 34'sd2147483647;
   localparam logic signed [33:0] SAT_MIN = -34'sd2147483648;

   logic [1:0] state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // coefficient registers
   logic [30:0] inv_jm_ff, inv_jl_ff, mdamp_ff, ldamp_ff, gear_ff, stiff_ff;
   logic [31:0] dt_ff;

   // actuator state, signed q16.16
   logic signed [31:0] ma_ff, ma_in, ms_ff, ms_in, la_ff, la_in, ls_ff, ls_in;

   // working registers
   logic signed [31:0] tau_ff, tau_in;
   logic signed [31:0] tmp_ff, tmp_in;
   logic signed [31:0] ts_ff, ts_in;
   logic signed [32:0] acc_ff, acc_in;
   logic [63:0]        prod_ff, prod_in;
   logic               neg_ff, neg_in;

   // response registers
   logic signed [31:0] rsp_ts_ff, rsp_ts_in, rsp_ma_ff, rsp_ma_in, rsp_ms_ff, rsp_ms_in;
   logic signed [31:0] rsp_la_ff, rsp_la_in, rsp_ls_ff, rsp_ls_in;

   sea_pkg::ctrl_type  ctrl;
   logic [31:0]        coef;
   logic signed [31:0] val;
   logic signed [31:0] base;
   logic [31:0]        mag;
   logic [63:0]        rnd;
   logic [47:0]        mag_r;
   logic signed [31:0] term;
   logic signed [33:0] sum;
   logic signed [31:0] sum_sat;
   logic               out_load;
   logic               write_en;

   assign ctrl = sea_pkg::step_ctrl(step_ff);

   // operand selection for the shared unit
   always_comb begin
      case (ctrl.coef_sel)
         sea_pkg::C_GEAR:  coef = {1'b0, gear_ff};
         sea_pkg::C_STIFF: coef = {1'b0, stiff_ff};
         sea_pkg::C_MDAMP: coef = {1'b0, mdamp_ff};
         sea_pkg::C_LDAMP: coef = {1'b0, ldamp_ff};
         sea_pkg::C_INVJM: coef = {1'b0, inv_jm_ff};
         sea_pkg::C_INVJL: coef = {1'b0, inv_jl_ff};
         sea_pkg::C_DT:    coef = dt_ff;
         default:          coef = '0;
      endcase
      case (ctrl.val_sel)
         sea_pkg::R_MA:  val = ma_ff;
         sea_pkg::R_MS:  val = ms_ff;
         sea_pkg::R_LA:  val = la_ff;
         sea_pkg::R_LS:  val = ls_ff;
         sea_pkg::R_TMP: val = tmp_ff;
         sea_pkg::R_TS:  val = ts_ff;
         default:        val = tau_ff;
      endcase
      case (ctrl.base_sel)
         sea_pkg::R_MA:  base = ma_ff;
         sea_pkg::R_MS:  base = ms_ff;
         sea_pkg::R_LA:  base = la_ff;
         sea_pkg::R_LS:  base = ls_ff;
         sea_pkg::R_TMP: base = tmp_ff;
         sea_pkg::R_TS:  base = ts_ff;
         default:        base = tau_ff;
      endcase
   end

   // multiply cycle: unsigned coefficient times magnitude of the signed operand
   // (the most negative value maps to 2^31, which fits 32 unsigned bits)
   always_comb begin
      neg_in  = val[31];
      mag     = val[31] ? (32'd0 - $unsigned(val)) : $unsigned(val);
      prod_in = {32'd0, coef} * {32'd0, mag};
   end

   // combine cycle: round half away from zero on the magnitude, reapply sign, saturate,
   // then pass the term or add or subtract it against the selected base or acc, and saturate
   always_comb begin
      rnd   = prod_ff + (ctrl.shift32 ? 64'h0000_0000_8000_0000 : 64'h0000_0000_0000_8000);
      mag_r = ctrl.shift32 ? {16'd0, rnd[63:32]} : rnd[63:16];
      if (neg_ff) begin
         if (mag_r >= 48'h0000_8000_0000) begin
            term = 32'sh8000_0000;
         end else begin
            term = $signed(32'd0 - mag_r[31:0]);
         end
      end else begin
         if (mag_r > 48'h0000_7FFF_FFFF) begin
            term = 32'sh7FFF_FFFF;
         end else begin
            term = $signed(mag_r[31:0]);
         end
      end

      case (ctrl.op)
         sea_pkg::OP_TERM:            sum = 34'(term);
         sea_pkg::OP_TERM_MINUS_BASE: sum = 34'(term) - 34'(base);
         sea_pkg::OP_BASE_MINUS_TERM: sum = 34'(base) - 34'(term);
         sea_pkg::OP_BASE_PLUS_TERM:  sum = 34'(base) + 34'(term);
         sea_pkg::OP_ACC_LOAD:        sum = 34'(base) - 34'(term);
         sea_pkg::OP_ACC_MINUS:       sum = 34'(acc_ff) - 34'(term);
         default:                     sum = 34'(term);
      endcase

      if (sum > SAT_MAX) begin
         sum_sat = 32'sh7FFF_FFFF;
      end else if (sum < SAT_MIN) begin
         sum_sat = 32'sh8000_0000;
      end else begin
         sum_sat = sum[31:0];
      end
   end

   // register write-back of the combine result; the torque-minus-damping difference is kept
   // unsaturated in acc until the gear term is taken off
   always_comb begin
      write_en = (state_ff == ST_COMB) && (ctrl.op != sea_pkg::OP_ACC_LOAD);
      ma_in  = ma_ff;
      ms_in  = ms_ff;
      la_in  = la_ff;
      ls_in  = ls_ff;
      tmp_in = tmp_ff;
      ts_in  = ts_ff;
      acc_in = acc_ff;
      if ((state_ff == ST_COMB) && (ctrl.op == sea_pkg::OP_ACC_LOAD)) begin
         acc_in = sum[32:0];
      end
      if (write_en) begin
         case (ctrl.dst_sel)
            sea_pkg::R_MA:  ma_in  = sum_sat;
            sea_pkg::R_MS:  ms_in  = sum_sat;
            sea_pkg::R_LA:  la_in  = sum_sat;
            sea_pkg::R_LS:  ls_in  = sum_sat;
            sea_pkg::R_TMP: tmp_in = sum_sat;
            sea_pkg::R_TS:  ts_in  = sum_sat;
            default: begin
            end
         endcase
      end
   end

   // sequencer: idle -> (multiply, combine) per step -> output load
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      tau_in   = tau_ff;
      out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               tau_in   = req_motor_torque;
               step_in  = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_COMB;
         end
         ST_COMB: begin
            if (step_ff == sea_pkg::STEP_LAST) begin
               state_in = ST_OUT;
            end else begin
               step_in  = step_ff + 4'd1;
               state_in = ST_MUL;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // response holds until taken; the next request may start meanwhile
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || out_load;
      rsp_ts_in = out_load ? ts_ff : rsp_ts_ff;
      rsp_ma_in = out_load ? ma_ff : rsp_ma_ff;
      rsp_ms_in = out_load ? ms_ff : rsp_ms_ff;
      rsp_la_in = out_load ? la_ff : rsp_la_ff;
      rsp_ls_in = out_load ? ls_ff : rsp_ls_ff;
   end

   // control, coefficients and actuator state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         ma_ff        <= '0;
         ms_ff        <= '0;
         la_ff        <= '0;
         ls_ff        <= '0;
         inv_jm_ff    <= sea_pkg::RST_INV_MOTOR_INERTIA;
         inv_jl_ff    <= sea_pkg::RST_INV_LOAD_INERTIA;
         mdamp_ff     <= sea_pkg::RST_MOTOR_DAMPING;
         ldamp_ff     <= sea_pkg::RST_LOAD_DAMPING;
         gear_ff      <= sea_pkg::RST_GEAR_RATIO;
         stiff_ff     <= sea_pkg::RST_SPRING_STIFFNESS;
         dt_ff        <= sea_pkg::RST_TIME_STEP;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         ma_ff        <= ma_in;
         ms_ff        <= ms_in;
         la_ff        <= la_in;
         ls_ff        <= ls_in;
         if (csr_write_en) begin
            case (csr_index)
               sea_pkg::CSR_INV_MOTOR_INERTIA: inv_jm_ff <= csr_wdata[30:0];
               sea_pkg::CSR_INV_LOAD_INERTIA:  inv_jl_ff <= csr_wdata[30:0];
               sea_pkg::CSR_MOTOR_DAMPING:     mdamp_ff  <= csr_wdata[30:0];
               sea_pkg::CSR_LOAD_DAMPING:      ldamp_ff  <= csr_wdata[30:0];
               sea_pkg::CSR_GEAR_RATIO:        gear_ff   <= csr_wdata[30:0];
               sea_pkg::CSR_SPRING_STIFFNESS:  stiff_ff  <= csr_wdata[30:0];
               sea_pkg::CSR_TIME_STEP:         dt_ff     <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // datapath payload, no reset needed
   always_ff @(posedge clock) begin
      tau_ff    <= tau_in;
      tmp_ff    <= tmp_in;
      ts_ff     <= ts_in;
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      neg_ff    <= neg_in;
      rsp_ts_ff <= rsp_ts_in;
      rsp_ma_ff <= rsp_ma_in;
      rsp_ms_ff <= rsp_ms_in;
      rsp_la_ff <= rsp_la_in;
      rsp_ls_ff <= rsp_ls_in;
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_spring_torque = rsp_ts_ff;
   assign rsp_motor_angle   = rsp_ma_ff;
   assign rsp_motor_speed   = rsp_ms_ff;
   assign rsp_load_angle    = rsp_la_ff;
   assign rsp_load_speed    = rsp_ls_ff;

`ifndef SYNTHESIS
   // an accepted request always starts the microcode at its first step
   a_start_step0: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_MUL) && (step_ff == 4'd0))
      else $error("request did not start at step zero");

   // the step counter never runs past the last microcode step
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (step_ff <= sea_pkg::STEP_LAST))
      else $error("step counter out of range");

   // a new response only appears right after the output load state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_OUT))
      else $error("response raised outside output load");
`endif

endmodule

// File: dv/sea_step_checker.sv
module sea_step_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [31:0] req_motor_torque,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_spring_torque,
   input  logic signed [31:0] rsp_motor_angle,
   input  logic signed [31:0] rsp_motor_speed,
   input  logic signed [31:0] rsp_load_angle,
   input  logic signed [31:0] rsp_load_speed,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   output int                 error_count,
   output int                 awaited
);

   localparam longint Q_HI = 64'sd2147483647;
   localparam longint Q_LO = -64'sd2147483648;

   typedef struct packed {
      logic signed [31:0] spring_torque;
      logic signed [31:0] motor_angle;
      logic signed [31:0] motor_speed;
      logic signed [31:0] load_angle;
      logic signed [31:0] load_speed;
   } actuator_state_type;

   logic [30:0] inv_jm, inv_jl, damp_m, damp_l, gear, stiff;
   logic [31:0] dt;
   longint      ma, ms, la, ls;
   int          errs = 0;

   actuator_state_type pending_states [$];

   function automatic longint clamp_q(input longint v);
      if (v > Q_HI) return Q_HI;
      if (v < Q_LO) return Q_LO;
      return v;
   endfunction

   // exact product, magnitude rounded half away from zero, sign back on, saturated
   function automatic longint scaled_product(input logic [31:0] coef, input longint v,
                                             input bit by_dt);
      longint unsigned mag;
      longint unsigned prod;
      int              sh;
      sh   = by_dt ? 32 : 16;
      mag  = (v < 0) ? -v : v;
      prod = {32'd0, coef} * mag;
      prod = (prod + (64'd1 << (sh - 1))) >> sh;
      if (v < 0) return (prod >= 64'd2147483648) ? Q_LO : -$signed(prod);
      return (prod > 64'd2147483647) ? Q_HI : $signed(prod);
   endfunction

   function automatic longint spring_from(input longint m_ang, input longint l_ang);
      longint twist;
      twist = clamp_q(scaled_product({1'b0, gear}, m_ang, 1'b0) - l_ang);
      return scaled_product({1'b0, stiff}, twist, 1'b0);
   endfunction

   // one semi-implicit euler step, speeds first, then angles with the new speeds
   function automatic actuator_state_type advance_actuator(input logic signed [31:0] torque);
      longint             ts, drive_m, drive_l, acc_m, acc_l;
      actuator_state_type nxt;
      ts      = spring_from(ma, la);
      drive_m = clamp_q(longint'(torque) - scaled_product({1'b0, damp_m}, ms, 1'b0)
                        - scaled_product({1'b0, gear}, ts, 1'b0));
      acc_m   = scaled_product({1'b0, inv_jm}, drive_m, 1'b0);
      drive_l = clamp_q(ts - scaled_product({1'b0, damp_l}, ls, 1'b0));
      acc_l   = scaled_product({1'b0, inv_jl}, drive_l, 1'b0);
      ms = clamp_q(ms + scaled_product(dt, acc_m, 1'b1));
      ma = clamp_q(ma + scaled_product(dt, ms, 1'b1));
      ls = clamp_q(ls + scaled_product(dt, acc_l, 1'b1));
      la = clamp_q(la + scaled_product(dt, ls, 1'b1));
      ts = spring_from(ma, la);
      nxt.spring_torque = ts[31:0];
      nxt.motor_angle   = ma[31:0];
      nxt.motor_speed   = ms[31:0];
      nxt.load_angle    = la[31:0];
      nxt.load_speed    = ls[31:0];
      return nxt;
   endfunction

   task automatic check_field(input string fname, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", fname, $signed(want), $signed(got));
         errs++;
      end
   endtask

   always @(posedge clock) begin
      actuator_state_type head;
      if (reset) begin
         inv_jm = sea_pkg::RST_INV_MOTOR_INERTIA;
         inv_jl = sea_pkg::RST_INV_LOAD_INERTIA;
         damp_m = sea_pkg::RST_MOTOR_DAMPING;
         damp_l = sea_pkg::RST_LOAD_DAMPING;
         gear   = sea_pkg::RST_GEAR_RATIO;
         stiff  = sea_pkg::RST_SPRING_STIFFNESS;
         dt     = sea_pkg::RST_TIME_STEP;
         ma = 0;
         ms = 0;
         la = 0;
         ls = 0;
         pending_states.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               sea_pkg::CSR_INV_MOTOR_INERTIA: inv_jm = csr_wdata[30:0];
               sea_pkg::CSR_INV_LOAD_INERTIA:  inv_jl = csr_wdata[30:0];
               sea_pkg::CSR_MOTOR_DAMPING:     damp_m = csr_wdata[30:0];
               sea_pkg::CSR_LOAD_DAMPING:      damp_l = csr_wdata[30:0];
               sea_pkg::CSR_GEAR_RATIO:        gear   = csr_wdata[30:0];
               sea_pkg::CSR_SPRING_STIFFNESS:  stiff  = csr_wdata[30:0];
               sea_pkg::CSR_TIME_STEP:         dt     = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            pending_states.push_back(advance_actuator(req_motor_torque));
         if (rsp_valid && rsp_ready) begin
            if (pending_states.size() == 0) begin
               $error("response with no request outstanding");
               errs++;
            end else begin
               head = pending_states.pop_front();
               check_field("spring_torque", head.spring_torque, rsp_spring_torque);
               check_field("motor_angle", head.motor_angle, rsp_motor_angle);
               check_field("motor_speed", head.motor_speed, rsp_motor_speed);
               check_field("load_angle", head.load_angle, rsp_load_angle);
               check_field("load_speed", head.load_speed, rsp_load_speed);
            end
         end
      end
      awaited     <= pending_states.size();
      error_count <= errs;
   end

endmodule

// File: dv/tb_top.sv
module tb_top;

   localparam int HALF_PERIOD   = 4;
   localparam int RESET_CYCLES  = 7;
   // slowest run is near 2k requests plus stalls; keep a wide margin
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = 40;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 300;
   localparam int HOLD_CYCLES   = 400;     // long receiver hold-off so the block backs up

   localparam logic [2:0]  CSR_NONE = 3'd7;   // past the last register, write must be dropped
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   // register write order, one entry per index
   localparam logic [2:0] CSR_ORDER [7] = '{
      sea_pkg::CSR_INV_MOTOR_INERTIA, sea_pkg::CSR_INV_LOAD_INERTIA,
      sea_pkg::CSR_MOTOR_DAMPING, sea_pkg::CSR_LOAD_DAMPING,
      sea_pkg::CSR_GEAR_RATIO, sea_pkg::CSR_SPRING_STIFFNESS, sea_pkg::CSR_TIME_STEP
   };

   localparam logic [31:0] RESET_SETTINGS [7] = '{
      32'(sea_pkg::RST_INV_MOTOR_INERTIA), 32'(sea_pkg::RST_INV_LOAD_INERTIA),
      32'(sea_pkg::RST_MOTOR_DAMPING), 32'(sea_pkg::RST_LOAD_DAMPING),
      32'(sea_pkg::RST_GEAR_RATIO), 32'(sea_pkg::RST_SPRING_STIFFNESS),
      sea_pkg::RST_TIME_STEP
   };

   // torque corner values: zero, one lsb, minus one lsb, both limits, +/- one newton-meter, upper limit twice more
   localparam logic [31:0] CORNER_TORQUES [9] = '{
      32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
      32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF
   };

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic signed [31:0] req_motor_torque = '0;
   logic               rsp_ready        = 1'b0;
   logic               csr_write_en     = 1'b0;
   logic [2:0]         csr_index        = sea_pkg::CSR_INV_MOTOR_INERTIA;
   logic [31:0]        csr_wdata        = '0;

   logic               req_ready;
   logic               rsp_valid;
   logic signed [31:0] rsp_spring_torque;
   logic signed [31:0] rsp_motor_angle;
   logic signed [31:0] rsp_motor_speed;
   logic signed [31:0] rsp_load_angle;
   logic signed [31:0] rsp_load_speed;

   int error_count;
   int awaited;
   int cycle_count  = 0;

   // shared between the request driver and the response sink
   bit calm_window  = 1'b0;   // no idling on either side
   bit hold_request = 1'b0;   // ask the sink for one long hold-off

   always #(HALF_PERIOD) clock = ~clock;

   series_elastic_actuator_step_unit uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_motor_torque  (req_motor_torque),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_spring_torque (rsp_spring_torque),
      .rsp_motor_angle   (rsp_motor_angle),
      .rsp_motor_speed   (rsp_motor_speed),
      .rsp_load_angle    (rsp_load_angle),
      .rsp_load_speed    (rsp_load_speed),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   sea_step_checker step_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_motor_torque  (req_motor_torque),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_spring_torque (rsp_spring_torque),
      .rsp_motor_angle   (rsp_motor_angle),
      .rsp_motor_speed   (rsp_motor_speed),
      .rsp_load_angle    (rsp_load_angle),
      .rsp_load_speed    (rsp_load_speed),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .error_count       (error_count),
      .awaited           (awaited)
   );

   // mostly small and moderate torques so the state evolves, with full-range noise and limits
   function automatic logic [31:0] pick_torque();
      logic [31:0] r;
      int unsigned mode;
      r    = $urandom;
      mode = $urandom_range(99);
      if (mode < 50) return {{12{r[19]}}, r[19:0]};
      if (mode < 75) return {{6{r[25]}}, r[25:0]};
      if (mode < 92) return r;
      case (r[1:0])
         2'd0: return 32'h7FFF_FFFF;
         2'd1: return 32'h8000_0000;
         2'd2: return 32'hFFFF_FFFF;
         default: return 32'h0000_0000;
      endcase
   endfunction

   // zero, all ones, full random (top bit too), or a scaled and jittered default
   function automatic logic [31:0] pick_setting(input int i);
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(9))
         0: return '0;
         1: return ALL_ONES;
         2, 3: return r;
         default: return ((RESET_SETTINGS[i] >> $urandom_range(3)) << $urandom_range(3)) ^ r[7:0];
      endcase
   endfunction

   // offer one request, sometimes after an idle gap, and hold it until accepted
   task automatic push_torque(input logic [31:0] torque);
      if (!calm_window && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(30, 1)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_motor_torque <= torque;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop offering and wait for every response plus the pipeline latency
   task automatic drain_block();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write all seven registers back to back, optionally poke the unused index too
   task automatic load_settings(input logic [31:0] vals [7], input bit poke_unused);
      for (int i = 0; i < 7; i++) begin
         csr_write_en <= 1'b1;
         csr_index    <= CSR_ORDER[i];
         csr_wdata    <= vals[i];
         @(posedge clock);
      end
      if (poke_unused) begin
         csr_write_en <= 1'b1;
         csr_index    <= CSR_NONE;
         csr_wdata    <= $urandom;
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // response sink: random stalls, one long hold-off on request, steady in the calm window
   initial begin : response_sink
      int  hold_left;
      bit  hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (calm_window) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 10);
         end
      end
   end

   // watchdog
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[series_elastic_actuator_step_unit] ERROR");
      $finish;
   end

   initial begin : stimulus
      logic [31:0] settings [7];
      logic [31:0] torque;
      int          run_left;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // torque corners on the reset settings
      for (int i = 0; i < 9; i++) push_torque(CORNER_TORQUES[i]);
      drain_block();

      // no inertia and no time step: accelerations and updates vanish
      settings = RESET_SETTINGS;
      settings[sea_pkg::CSR_INV_MOTOR_INERTIA] = '0;
      settings[sea_pkg::CSR_INV_LOAD_INERTIA]  = '0;
      settings[sea_pkg::CSR_TIME_STEP]         = '0;
      load_settings(settings, 1'b1);
      push_torque(32'h7FFF_FFFF);
      push_torque(32'h8000_0000);
      push_torque(32'h1234_5678);
      drain_block();

      // nearly one-second step on default plant
      settings = RESET_SETTINGS;
      settings[sea_pkg::CSR_TIME_STEP] = ALL_ONES;
      load_settings(settings, 1'b0);
      push_torque(32'h0001_0000);
      push_torque(32'hFFFF_0000);
      push_torque(32'h7FFF_FFFF);
      push_torque(32'h8000_0000);
      drain_block();

      // every register at its top, bits above the width set as well: saturation everywhere
      for (int i = 0; i < 7; i++) settings[i] = ALL_ONES;
      load_settings(settings, 1'b1);
      push_torque(32'h8000_0000);
      push_torque(32'h7FFF_FFFF);
      push_torque(32'h0000_0000);
      drain_block();

      // random phases: runs of held torque so the plant actually moves, plus noise
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         for (int i = 0; i < 7; i++)
            settings[i] = (p == 0) ? RESET_SETTINGS[i] : pick_setting(i);
         load_settings(settings, p[0]);
         calm_window = (p == 2);
         run_left    = 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 1 && n == 40) hold_request = 1'b1;
            if (run_left == 0) begin
               torque   = pick_torque();
               run_left = ($urandom_range(3) == 0) ? 1 : $urandom_range(24, 2);
            end
            push_torque(torque);
            run_left--;
         end
         drain_block();
      end
      calm_window = 1'b0;

      if (error_count == 0 && awaited == 0) begin
         $display("[series_elastic_actuator_step_unit] OK");
      end else begin
         $display("[series_elastic_actuator_step_unit] ERROR");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/sea_pkg.sv
sv/series_elastic_actuator_step_unit.sv
dv/sea_step_checker.sv
dv/tb_top.sv
